[rtl/irs_pkg.sv]
// Shared constants and types for the interval running statistics block.
`default_nettype none

package irs_pkg;

  // Default sizes of the internal state
  localparam int unsigned TIME_BITS_DEF      = 48;
  localparam int unsigned INTERVAL_BITS_DEF  = 32;
  localparam int unsigned MEAN_FRAC_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF     = 32;

  // Port field widths
  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned TIMESTAMP_W  = 48;
  localparam int unsigned LAST_W       = 32;
  localparam int unsigned MEAN_OUT_W   = 48;
  localparam int unsigned MIN_W        = 32;
  localparam int unsigned MAX_W        = 32;
  localparam int unsigned STD_W        = 32;
  localparam int unsigned COUNT_OUT_W  = 32;

  localparam int unsigned IN_TDATA_W   = 48;
  localparam int unsigned OUT_TDATA_W  = LAST_W + MEAN_OUT_W + MIN_W + MAX_W + STD_W
                                         + COUNT_OUT_W;

  // Datapath word width of the shared add/sub unit and the work registers
  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = WORD_W / 2;
  localparam int unsigned PROD_W = 2 * WORD_W;

  // Item opcodes; the fourth code is unused and reports the statistics unchanged
  typedef enum logic [OPCODE_W-1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_CLEAR = 2'd2
  } irs_op_e;

endpackage

`default_nettype wire

[rtl/interval_running_statistics_top.sv]
// Interval running statistics: count, Welford mean, deviation sum, min, max, std.
//
//  channel  | dir | tdata (low bit up)                           | tuser
//  ---------+-----+----------------------------------------------+-------------
//  s_axis   | in  | timestamp_ns[47:0]                           | opcode[1:0]
//  m_axis   | out | last_ns, mean_q16, min_ns, max_ns, std_ns,   | has_samples
//           |     | sample_count (32,48,32,32,32,32 bits)        |
//
//  Start, clear, the unused opcode and a first stop: result valid the cycle after
//  accept. A later stop: compare, abs difference, a 64-step restoring division,
//  mean update, deviation, a 32x32 partial product multiply, accumulate, a second
//  64-step division and a 32-step square root, on one shared 64-bit add/sub unit.
//  s_axis_tready is high only while idle; the result holds on m_axis until taken.
//  Reset (rst_ni low) clears all statistics, min to all ones.
`default_nettype none

module interval_running_statistics_top #(
  parameter int unsigned TIME_BITS      = irs_pkg::TIME_BITS_DEF,
  parameter int unsigned INTERVAL_BITS  = irs_pkg::INTERVAL_BITS_DEF,
  parameter int unsigned MEAN_FRAC_BITS = irs_pkg::MEAN_FRAC_BITS_DEF,
  parameter int unsigned COUNT_BITS     = irs_pkg::COUNT_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // timestamp_ns[47:0]
  input  wire logic [irs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // opcode[1:0]
  input  wire logic [irs_pkg::OPCODE_W-1:0]     s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // last_ns[31:0], mean_q16[79:32], min_ns[111:80], max_ns[143:112],
  // std_ns[175:144], sample_count[207:176]
  output logic [irs_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // has_samples[0]
  output logic                                  m_axis_tuser
);

  localparam int unsigned W  = irs_pkg::WORD_W;
  localparam int unsigned HW = irs_pkg::HALF_W;
  localparam int unsigned PW = irs_pkg::PROD_W;

  localparam int unsigned DIV_LAST  = W - 1;
  localparam int unsigned SQRT_LAST = W / 2 - 1;
  localparam int unsigned MUL_LAST  = 4;
  localparam int unsigned STEP_W    = $clog2(W);

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CMP  = 4'd1;
  localparam logic [3:0] ST_ABS  = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_MEAN = 4'd4;
  localparam logic [3:0] ST_DEV  = 4'd5;
  localparam logic [3:0] ST_MUL  = 4'd6;
  localparam logic [3:0] ST_ACC  = 4'd7;
  localparam logic [3:0] ST_SQRT = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  // Statistics state
  logic [TIME_BITS-1:0]     start_q;
  logic [INTERVAL_BITS-1:0] last_q;
  logic [W-1:0]             mean_q;
  logic [W-1:0]             dev_q;
  logic [INTERVAL_BITS-1:0] min_q;
  logic [INTERVAL_BITS-1:0] max_q;
  logic [COUNT_BITS-1:0]    cnt_q;
  logic [irs_pkg::STD_W-1:0] std_q;

  // Sequencer and work registers
  logic [3:0]            state_q, state_d;
  logic [STEP_W-1:0]     step_q;
  logic                  div_sel_q;   // 0: mean step, 1: deviation sum over count
  logic                  ge_q;        // new interval at or above the mean
  logic [W-1:0]          xq_q;
  logic [W-1:0]          dvd_q;       // dividend shifting out, quotient shifting in
  logic [COUNT_BITS-1:0] rem_q;
  logic [W-1:0]          dabs_q;
  logic [W-1:0]          bfac_q;
  logic [W-1:0]          pp_q;
  logic [PW-1:0]         acc_q;
  logic [W-1:0]          res_q;
  logic [W-1:0]          bit_q;

  // Input decode
  logic                     in_fire;
  logic [W-1:0]             ts_ext;
  logic [TIME_BITS-1:0]     ts_t;
  logic [TIME_BITS-1:0]     span;
  logic [W-1:0]             span64;
  logic [INTERVAL_BITS-1:0] x_w;
  logic [W-1:0]             xq_w;
  logic [COUNT_BITS-1:0]    cnt_inc;
  logic                     cnt_empty;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign ts_ext    = W'(s_axis_tdata);
  assign ts_t      = ts_ext[TIME_BITS-1:0];
  assign span      = ts_t - start_q;
  assign span64    = W'(span);
  assign x_w       = (|span64[W-1:INTERVAL_BITS]) ? {INTERVAL_BITS{1'b1}}
                                                  : span64[INTERVAL_BITS-1:0];
  assign xq_w      = W'(x_w) << MEAN_FRAC_BITS;
  assign cnt_empty = (cnt_q == '0);
  assign cnt_inc   = (cnt_q == {COUNT_BITS{1'b1}}) ? cnt_q : cnt_q + COUNT_BITS'(1);

  // Shared add/sub unit
  logic [W-1:0] alu_a, alu_b;
  logic         alu_sub;
  logic [W:0]   alu_y;
  logic         alu_ge;
  logic [W-1:0] acc_inc;

  logic [COUNT_BITS:0] div_r;
  logic [W-1:0]        sq_trial;

  assign div_r    = {rem_q, dvd_q[W-1]};
  assign sq_trial = res_q | bit_q;

  always_comb begin
    alu_a   = xq_q;
    alu_b   = mean_q;
    alu_sub = 1'b1;
    case (state_q)
      ST_CMP: begin
        alu_a = xq_q;
        alu_b = mean_q;
      end
      ST_ABS, ST_DEV: begin
        alu_a = ge_q ? xq_q : mean_q;
        alu_b = ge_q ? mean_q : xq_q;
      end
      ST_DIV: begin
        alu_a = W'(div_r);
        alu_b = W'(cnt_q);
      end
      ST_MEAN: begin
        alu_a   = mean_q;
        alu_b   = dvd_q;
        alu_sub = !ge_q;
      end
      ST_ACC: begin
        alu_a   = dev_q;
        alu_b   = acc_inc;
        alu_sub = 1'b0;
      end
      ST_SQRT: begin
        alu_a = dvd_q;
        alu_b = sq_trial;
      end
      default: begin
        alu_a = xq_q;
        alu_b = mean_q;
      end
    endcase
  end

  assign alu_y  = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                          : ({1'b0, alu_a} + {1'b0, alu_b});
  assign alu_ge = !alu_y[W];

  // 32x32 partial products, one per cycle, each registered and accumulated in the following cycle
  logic [HW-1:0] mul_a, mul_b;
  logic [PW-1:0] pp_sh;
  logic [PW-1:0] acc_sh;

  always_comb begin
    case (step_q[2:0])
      3'd0: begin
        mul_a = dabs_q[HW-1:0];
        mul_b = bfac_q[HW-1:0];
      end
      3'd1: begin
        mul_a = dabs_q[HW-1:0];
        mul_b = bfac_q[W-1:HW];
      end
      3'd2: begin
        mul_a = dabs_q[W-1:HW];
        mul_b = bfac_q[HW-1:0];
      end
      default: begin
        mul_a = dabs_q[W-1:HW];
        mul_b = bfac_q[W-1:HW];
      end
    endcase
  end

  always_comb begin
    case (step_q[2:0])
      3'd1:       pp_sh = PW'(pp_q);
      3'd2, 3'd3: pp_sh = PW'(pp_q) << HW;
      default:    pp_sh = PW'(pp_q) << W;
    endcase
  end

  // Product scaled back by both fraction widths, saturated to one word
  assign acc_sh  = acc_q >> (2 * MEAN_FRAC_BITS);
  assign acc_inc = (|acc_sh[PW-1:W]) ? {W{1'b1}} : acc_sh[W-1:0];

  // Square root step result
  logic [W-1:0] sq_res_n;
  assign sq_res_n = alu_ge ? ((res_q >> 1) | bit_q) : (res_q >> 1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if ((irs_pkg::irs_op_e'(s_axis_tuser) == irs_pkg::OP_STOP) && !cnt_empty) begin
            state_d = ST_CMP;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_CMP:  state_d = ST_ABS;
      ST_ABS:  state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == STEP_W'(DIV_LAST)) begin
          state_d = div_sel_q ? ST_SQRT : ST_MEAN;
        end
      end
      ST_MEAN: state_d = ST_DEV;
      ST_DEV:  state_d = ST_MUL;
      ST_MUL: begin
        if (step_q == STEP_W'(MUL_LAST)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC:  state_d = ST_DIV;
      ST_SQRT: begin
        if (step_q == STEP_W'(SQRT_LAST)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      start_q <= '0;
      last_q  <= '0;
      mean_q  <= '0;
      dev_q   <= '0;
      min_q   <= {INTERVAL_BITS{1'b1}};
      max_q   <= '0;
      cnt_q   <= '0;
      std_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (in_fire) begin
            case (irs_pkg::irs_op_e'(s_axis_tuser))
              irs_pkg::OP_START: begin
                start_q <= ts_t;
              end
              irs_pkg::OP_STOP: begin
                start_q <= ts_t;
                last_q  <= x_w;
                cnt_q   <= cnt_inc;
                if (x_w < min_q) begin
                  min_q <= x_w;
                end
                if (x_w > max_q) begin
                  max_q <= x_w;
                end
                // first sample: the mean is the sample, deviation stays zero
                if (cnt_empty) begin
                  mean_q <= xq_w;
                  std_q  <= '0;
                end
              end
              irs_pkg::OP_CLEAR: begin
                start_q <= '0;
                last_q  <= '0;
                mean_q  <= '0;
                dev_q   <= '0;
                min_q   <= {INTERVAL_BITS{1'b1}};
                max_q   <= '0;
                cnt_q   <= '0;
                std_q   <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV, ST_MUL: begin
          step_q <= (state_d == state_q) ? step_q + STEP_W'(1) : '0;
        end
        ST_MEAN: begin
          mean_q <= alu_y[W-1:0];
        end
        ST_ACC: begin
          dev_q  <= alu_y[W] ? {W{1'b1}} : alu_y[W-1:0];
          step_q <= '0;
        end
        ST_SQRT: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(SQRT_LAST)) begin
            std_q <= sq_res_n[irs_pkg::STD_W-1:0];
          end
        end
        default: begin
          step_q <= '0;
        end
      endcase
    end
  end

  // Datapath work registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        xq_q <= xq_w;
      end
      ST_CMP: begin
        ge_q <= alu_ge;
      end
      ST_ABS: begin
        dvd_q     <= alu_y[W-1:0];
        dabs_q    <= alu_y[W-1:0];
        rem_q     <= '0;
        div_sel_q <= 1'b0;
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_q <= alu_ge ? alu_y[COUNT_BITS-1:0] : div_r[COUNT_BITS-1:0];
        dvd_q <= {dvd_q[W-2:0], alu_ge};
        res_q <= '0;
        bit_q <= W'(1) << (W - 2);
      end
      ST_DEV: begin
        bfac_q <= alu_y[W-1:0];
        acc_q  <= '0;
      end
      ST_MUL: begin
        if (step_q < STEP_W'(MUL_LAST)) begin
          pp_q <= W'(mul_a) * W'(mul_b);
        end
        if (step_q != '0) begin
          acc_q <= acc_q + pp_sh;
        end
      end
      ST_ACC: begin
        dvd_q     <= alu_y[W] ? {W{1'b1}} : alu_y[W-1:0];
        rem_q     <= '0;
        div_sel_q <= 1'b1;
      end
      ST_SQRT: begin
        if (alu_ge) begin
          dvd_q <= alu_y[W-1:0];
        end
        res_q <= sq_res_n;
        bit_q <= bit_q >> 2;
      end
      default: begin
      end
    endcase
  end

  // Output channel
  logic [W-1:0] last64, min64, max64, cnt64;

  assign last64 = W'(last_q);
  assign min64  = W'(min_q);
  assign max64  = W'(max_q);
  assign cnt64  = W'(cnt_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {cnt64[irs_pkg::COUNT_OUT_W-1:0],
                          std_q,
                          max64[irs_pkg::MAX_W-1:0],
                          min64[irs_pkg::MIN_W-1:0],
                          mean_q[irs_pkg::MEAN_OUT_W-1:0],
                          last64[irs_pkg::LAST_W-1:0]};
  assign m_axis_tuser  = !cnt_empty;

  // Checks
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output sides active together");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cnt_empty |-> (min_q <= max_q))
    else $error("min above max with samples present");

  a_empty_dev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_empty |-> (dev_q == '0) && (std_q == '0))
    else $error("deviation nonzero without samples");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (irs_pkg::irs_op_e'(s_axis_tuser) == irs_pkg::OP_CLEAR))
      |=> cnt_empty && (max_q == '0) && (start_q == '0))
    else $error("clear did not restore state");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < cnt_q))
    else $error("division remainder out of range");

endmodule

`default_nettype wire
